FILE: hw/rtl/handle_table_allocator_defines.svh
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

// check cons in the same cycle as ante
`define HTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define HTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/hta_pkg.sv
package hta_pkg;

   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int HANDLE_W      = 16;
   localparam int LOCAL_W       = 8;
   localparam int SLOT_W        = 7;
   localparam int RESET_ENTRIES = 3;
   localparam int CLOSE_MIN     = 2;
   localparam int LOOKUP_MIN    = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN   = 2'd0,
      CMD_CLOSE  = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_TEST   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SCAN = 3'b100
   } state_type;

endpackage

FILE: hw/rtl/hta_host_map.sv
module hta_host_map #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [hta_pkg::HANDLE_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [hta_pkg::HANDLE_W-1:0] rd_data
);

   logic [hta_pkg::HANDLE_W-1:0] mem [DEPTH];
   logic [hta_pkg::HANDLE_W-1:0] rd_q_ff;
   logic [AW-1:0]                rd_idx_ff;
   logic                         rd_ovr_ff;
   logic                         rd_ovr_in;
   logic [hta_pkg::RESET_ENTRIES-1:0] init_ff;
   logic [hta_pkg::RESET_ENTRIES-1:0] init_in;

   always_comb begin
      rd_ovr_in = 1'b0;
      init_in   = init_ff;
      for (int i = 0; i < hta_pkg::RESET_ENTRIES; i++) begin
         if (rd_addr == AW'(i) && init_ff[i]) begin
            rd_ovr_in = 1'b1;
         end
         if (wr_en && wr_addr == AW'(i)) begin
            init_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff   <= mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff   <= '1;
         rd_ovr_ff <= 1'b0;
      end else begin
         init_ff <= init_in;
         if (rd_en) begin
            rd_ovr_ff <= rd_ovr_in;
         end
      end
   end

   assign rd_data = rd_ovr_ff ? hta_pkg::HANDLE_W'(rd_idx_ff) : rd_q_ff;

endmodule

FILE: hw/rtl/handle_table_allocator.sv
// Handle table: maps local handles (entry indices) to 16-bit host handles.
// Raise start with a command while busy is low; the item is taken at that edge
// and its single result shows on the rsp_ ports for exactly one cycle, marked
// by rsp_strobe. The receiver cannot stall, so every result must be captured
// in its strobe cycle. Test-open and any rejected close or lookup answer in the
// cycle after acceptance; an accepted close or lookup passes through S_READ and
// then the result register. Open scans the host-handle memory one entry per
// cycle through its single read port; it answers once the lowest occupied entry
// holding the handle is found, and after the last entry is checked otherwise.
// busy is low in the cycle the result shows, so a new item may be taken there.
// Entries 0 to 2 hold host handles 0 to 2 after reset and are usable at once; no
// clearing pass is needed.
`include "handle_table_allocator_defines.svh"

module handle_table_allocator #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [hta_pkg::CMD_W-1:0]       req_cmd,
   input  logic [hta_pkg::HANDLE_W-1:0]    req_host_handle,
   input  logic [hta_pkg::LOCAL_W-1:0]     req_local_handle,
   output logic                            rsp_strobe,
   output logic [hta_pkg::STATUS_W-1:0]    rsp_status,
   output logic [hta_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [hta_pkg::HANDLE_W-1:0]    rsp_found_handle,
   output logic                            rsp_opened
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   hta_pkg::state_type           state_ff, state_in;
   logic [TABLE_DEPTH-1:0]       occ_ff, occ_in;
   logic [hta_pkg::HANDLE_W-1:0] host_ff, host_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic                         close_ff, close_in;
   logic [CW-1:0]                issue_ff, issue_in;
   logic [AW-1:0]                chk_ff, chk_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                free_ff, free_in;
   logic                         free_vld_ff, free_vld_in;

   logic                         rsp_strobe_ff, rsp_strobe_in;
   hta_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [hta_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [hta_pkg::HANDLE_W-1:0] rsp_found_ff, rsp_found_in;
   logic                         rsp_opened_ff, rsp_opened_in;

   logic                         mem_wr_en;
   logic [AW-1:0]                mem_wr_addr;
   logic                         mem_rd_en;
   logic [AW-1:0]                mem_rd_addr;
   logic [hta_pkg::HANDLE_W-1:0] mem_rd_data;

   logic                         in_table;
   logic [AW-1:0]                req_idx;
   logic                         chk_match;
   logic                         chk_free;
   logic                         scan_free_vld;
   logic [AW-1:0]                scan_free_slot;

   hta_host_map #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_host_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (host_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign in_table       = req_local_handle < hta_pkg::LOCAL_W'(TABLE_DEPTH);
   assign req_idx        = req_local_handle[AW-1:0];
   assign chk_match      = occ_ff[chk_ff] && (mem_rd_data == host_ff);
   assign chk_free       = !occ_ff[chk_ff];
   assign scan_free_vld  = free_vld_ff || chk_free;
   assign scan_free_slot = free_vld_ff ? free_ff : chk_ff;

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      host_in       = host_ff;
      idx_in        = idx_ff;
      close_in      = close_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      free_in       = free_ff;
      free_vld_in   = free_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_opened_in = rsp_opened_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = free_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = req_idx;

      case (state_ff)
         hta_pkg::S_IDLE: begin
            if (start) begin
               rsp_slot_in   = '0;
               rsp_found_in  = '0;
               rsp_opened_in = 1'b0;
               case (req_cmd)
                  hta_pkg::CMD_OPEN: begin
                     host_in     = req_host_handle;
                     issue_in    = '0;
                     chk_vld_in  = 1'b0;
                     free_vld_in = 1'b0;
                     state_in    = hta_pkg::S_SCAN;
                  end
                  hta_pkg::CMD_CLOSE, hta_pkg::CMD_LOOKUP: begin
                     if (in_table && occ_ff[req_idx] &&
                         ((req_cmd == hta_pkg::CMD_CLOSE &&
                           req_local_handle >= hta_pkg::LOCAL_W'(hta_pkg::CLOSE_MIN)) ||
                          (req_cmd == hta_pkg::CMD_LOOKUP &&
                           req_local_handle >= hta_pkg::LOCAL_W'(hta_pkg::LOOKUP_MIN)))) begin
                        mem_rd_en = 1'b1;
                        idx_in    = req_idx;
                        close_in  = (req_cmd == hta_pkg::CMD_CLOSE);
                        state_in  = hta_pkg::S_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = hta_pkg::ST_INVALID;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = in_table ? hta_pkg::ST_OK : hta_pkg::ST_INVALID;
                     rsp_opened_in = in_table && occ_ff[req_idx];
                  end
               endcase
            end
         end
         hta_pkg::S_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = hta_pkg::ST_OK;
            rsp_found_in  = mem_rd_data;
            if (close_ff) begin
               occ_in[idx_ff] = 1'b0;
            end
            state_in = hta_pkg::S_IDLE;
         end
         hta_pkg::S_SCAN: begin
            // advance the read pointer one entry per cycle
            if (issue_ff < CW'(TABLE_DEPTH)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = issue_ff[AW-1:0];
               issue_in    = issue_ff + CW'(1);
               chk_in      = issue_ff[AW-1:0];
               chk_vld_in  = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               if (chk_match) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = hta_pkg::ST_OK;
                  rsp_slot_in   = hta_pkg::SLOT_W'(chk_ff);
                  state_in      = hta_pkg::S_IDLE;
               end else begin
                  if (chk_free && !free_vld_ff) begin
                     free_in     = chk_ff;
                     free_vld_in = 1'b1;
                  end
                  if (chk_ff == AW'(TABLE_DEPTH - 1)) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = hta_pkg::S_IDLE;
                     if (scan_free_vld) begin
                        mem_wr_en              = 1'b1;
                        mem_wr_addr            = scan_free_slot;
                        occ_in[scan_free_slot] = 1'b1;
                        rsp_status_in          = hta_pkg::ST_OK;
                        rsp_slot_in            = hta_pkg::SLOT_W'(scan_free_slot);
                     end else begin
                        rsp_status_in = hta_pkg::ST_FULL;
                        rsp_slot_in   = '0;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = hta_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hta_pkg::S_IDLE;
         occ_ff        <= TABLE_DEPTH'((1 << hta_pkg::RESET_ENTRIES) - 1);
         chk_vld_ff    <= 1'b0;
         free_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         chk_vld_ff    <= chk_vld_in;
         free_vld_ff   <= free_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      host_ff       <= host_in;
      idx_ff        <= idx_in;
      close_ff      <= close_in;
      issue_ff      <= issue_in;
      chk_ff        <= chk_in;
      free_ff       <= free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_opened_ff <= rsp_opened_in;
   end

   assign busy             = (state_ff != hta_pkg::S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_found_handle = rsp_found_ff;
   assign rsp_opened       = rsp_opened_ff;

   `HTA_ASSERT_NOW(a_rsp_not_busy, clock, reset, rsp_strobe, !busy, "result shown while busy")
   `HTA_ASSERT_NOW(a_std_entries_held, clock, reset, 1'b1, occ_ff[0] && occ_ff[1],
                   "entry 0 or 1 freed")
   `HTA_ASSERT_NEXT(a_test_one_cycle, clock, reset,
                    start && !busy && req_cmd == hta_pkg::CMD_TEST, rsp_strobe,
                    "test-open result late")
   `HTA_ASSERT_NOW(a_full_means_full, clock, reset,
                   rsp_strobe && rsp_status == hta_pkg::ST_FULL, &occ_ff,
                   "full reported with a free entry")

endmodule
